/* hw/rtl/ppc_pkg.sv */
// Shared types and fixed widths for the polygon area, perimeter and centroid block.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
package ppc_pkg;

    localparam int AREA_W      = 41;
    localparam int PERIM_W     = 25;
    localparam int CENTER_W    = 16;
    localparam int COUNT_OUT_W = 9;

    typedef enum logic [1:0] {
        MUL_DX    = 2'd0,
        MUL_DY    = 2'd1,
        MUL_CROSS = 2'd2
    } mul_sel_t;

    typedef struct packed {
        logic     capture;
        logic     init;
        logic     set_ovf;
        logic     load_edge;
        logic     close_sel;
        logic     advance;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     rad_load;
        logic     rad_add;
        logic     acc_add;
        logic     sqrt_start;
        logic     perim_add;
        logic     div_start;
        logic     div_sel;
        logic     cen_x_load;
        logic     cen_y_load;
        logic     emit;
    } dp_cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic cnt_full;
        logic last;
        logic sqrt_done;
        logic div_done;
    } dp_stat_t;

endpackage

/* hw/rtl/ppc_sqrt.sv */
// Iterative integer square root, one root bit per cycle, truncating.
// Stand-alone unit used by the datapath.
`timescale 1ns / 1ps
module ppc_sqrt #(
    parameter int RAD_W = 34
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [RAD_W-1:0]       radicand,
    output logic [RAD_W/2-1:0]     root,
    output logic                   done
);
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 1;
    localparam int SW     = $clog2(ROOT_W);

    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [SW-1:0]     step_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] trial;
    logic             fits;

    assign rem_sh = {rem_reg, rad_reg[RAD_W-1:RAD_W-2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign fits   = (rem_sh >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= SW'(ROOT_W - 1);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
            if (fits)
            begin
                rem_reg  <= REM_W'(rem_sh - trial);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh[REM_W-1:0];
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

/* hw/rtl/ppc_div.sv */
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
// Shared by both centroid coordinates.
`timescale 1ns / 1ps
module ppc_div #(
    parameter int DW = 24,
    parameter int VW = 9
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [DW-1:0] dividend,
    input  logic [VW-1:0]        divisor,
    output logic signed [DW-1:0] quotient,
    output logic                 done
);
    localparam int SW = $clog2(DW);

    logic [DW-1:0] q_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] dvs_reg;
    logic          neg_reg;
    logic [SW-1:0] step_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [DW-1:0] mag;
    logic [VW:0]   rem_sh;
    logic          fits;

    assign mag    = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
    assign rem_sh = {rem_reg, q_reg[DW-1]};
    assign fits   = (rem_sh >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= SW'(DW - 1);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= mag;
            rem_reg <= '0;
            dvs_reg <= divisor;
            neg_reg <= dividend[DW-1];
        end
        else if (busy_reg)
        begin
            // The remainder stays below the divisor, so it fits in VW bits.
            rem_reg <= fits ? VW'(rem_sh - {1'b0, dvs_reg}) : rem_sh[VW-1:0];
            q_reg   <= {q_reg[DW-2:0], fits};
        end
    end

    assign quotient = neg_reg ? DW'(-q_reg) : DW'(q_reg);
    assign done     = done_reg;

endmodule

/* hw/rtl/ppc_dp.sv */
// Datapath: vertex registers, edge multiplier, accumulators and result registers.
// Depends on ppc_pkg, ppc_sqrt and ppc_div.
`timescale 1ns / 1ps
module ppc_dp
    import ppc_pkg::*;
#(
    parameter int MAX_VERTICES = 256,
    parameter int COORD_BITS   = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic signed [COORD_BITS-1:0]  vertex_x,
    input  logic signed [COORD_BITS-1:0]  vertex_y,
    input  logic                          last_vertex,
    input  dp_cmd_t                       cmd,
    output dp_stat_t                      stat,
    output logic [AREA_W-1:0]             area_mag,
    output logic [PERIM_W-1:0]            perimeter_len,
    output logic signed [CENTER_W-1:0]    center_x,
    output logic signed [CENTER_W-1:0]    center_y,
    output logic [COUNT_OUT_W-1:0]        vertex_count,
    output logic                          count_overflow
);
    localparam int CW     = COORD_BITS;
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int SUM_W  = CW + CNT_W;
    localparam int EW     = CW + 1;
    localparam int PROD_W = 2 * EW;
    localparam int ROOT_W = PROD_W / 2;
    localparam int ACC_W0 = PROD_W + CNT_W;
    localparam int ACC_W  = (ACC_W0 > AREA_W) ? ACC_W0 : AREA_W + 1;
    localparam int PS_W   = ((PERIM_W > ROOT_W) ? PERIM_W : ROOT_W) + 1;
    localparam int DQ_W   = (SUM_W > CENTER_W) ? SUM_W : CENTER_W;
    localparam int CX_W   = (CNT_W > COUNT_OUT_W) ? CNT_W : COUNT_OUT_W;

    logic signed [CW-1:0]       vx_reg, vy_reg;
    logic                       last_reg;
    logic signed [CW-1:0]       first_x_reg, first_y_reg, prev_x_reg, prev_y_reg;
    logic signed [SUM_W-1:0]    sum_x_reg, sum_y_reg;
    logic [CNT_W-1:0]           count_reg;
    logic                       ovf_reg;
    logic signed [EW-1:0]       dx_reg, dy_reg, sx_reg;
    logic signed [PROD_W-1:0]   mul_reg;
    logic [PROD_W-1:0]          rad_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic [PERIM_W-1:0]         perim_reg;
    logic signed [CENTER_W-1:0] cen_x_reg, cen_y_reg;
    logic [AREA_W-1:0]          area_reg;
    logic [PERIM_W-1:0]         perim_out_reg;
    logic signed [CENTER_W-1:0] cx_out_reg, cy_out_reg;
    logic [COUNT_OUT_W-1:0]     cnt_out_reg;
    logic                       ovf_out_reg;

    logic signed [CW-1:0]     bx, by;
    logic signed [EW-1:0]     mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic [ROOT_W-1:0]        root;
    logic                     sqrt_done;
    logic [PS_W-1:0]          psum;
    logic [PS_W-1:0]          perim_max;
    logic signed [DQ_W-1:0]   dividend;
    logic signed [DQ_W-1:0]   quotient;
    logic                     div_done;
    logic [ACC_W-1:0]         acc_mag;
    logic [AREA_W-1:0]        area_next;
    logic [CX_W-1:0]          cnt_ext;
    logic [COUNT_OUT_W-1:0]   cnt_next;

    assign bx = cmd.close_sel ? first_x_reg : vx_reg;
    assign by = cmd.close_sel ? first_y_reg : vy_reg;

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_DX:
            begin
                mul_a = dx_reg;
                mul_b = dx_reg;
            end
            MUL_DY:
            begin
                mul_a = dy_reg;
                mul_b = dy_reg;
            end
            default:
            begin
                mul_a = sx_reg;
                mul_b = dy_reg;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    ppc_sqrt #(.RAD_W(PROD_W)) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (rad_reg),
        .root     (root),
        .done     (sqrt_done)
    );

    assign psum      = PS_W'(perim_reg) + PS_W'(root);
    assign perim_max = PS_W'({PERIM_W{1'b1}});

    assign dividend = cmd.div_sel ? DQ_W'(sum_y_reg) : DQ_W'(sum_x_reg);

    ppc_div #(.DW(DQ_W), .VW(CNT_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (count_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    assign acc_mag   = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign area_next = (|acc_mag[ACC_W-1:AREA_W]) ? {AREA_W{1'b1}} : acc_mag[AREA_W-1:0];
    assign cnt_ext   = CX_W'(count_reg);
    assign cnt_next  = (cnt_ext > CX_W'({COUNT_OUT_W{1'b1}})) ? {COUNT_OUT_W{1'b1}}
                                                               : COUNT_OUT_W'(cnt_ext);

    // Polygon state: cleared by reset and again after each result is loaded.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_x_reg <= '0;
            first_y_reg <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            sum_x_reg   <= '0;
            sum_y_reg   <= '0;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            acc_reg     <= '0;
            perim_reg   <= '0;
        end
        else if (cmd.emit)
        begin
            first_x_reg <= '0;
            first_y_reg <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            sum_x_reg   <= '0;
            sum_y_reg   <= '0;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            acc_reg     <= '0;
            perim_reg   <= '0;
        end
        else
        begin
            if (cmd.init)
            begin
                first_x_reg <= vx_reg;
                first_y_reg <= vy_reg;
                prev_x_reg  <= vx_reg;
                prev_y_reg  <= vy_reg;
                sum_x_reg   <= SUM_W'(vx_reg);
                sum_y_reg   <= SUM_W'(vy_reg);
                count_reg   <= CNT_W'(1);
            end
            if (cmd.advance)
            begin
                prev_x_reg <= vx_reg;
                prev_y_reg <= vy_reg;
                sum_x_reg  <= sum_x_reg + SUM_W'(vx_reg);
                sum_y_reg  <= sum_y_reg + SUM_W'(vy_reg);
                count_reg  <= count_reg + 1'b1;
            end
            if (cmd.set_ovf)
            begin
                ovf_reg <= 1'b1;
            end
            if (cmd.acc_add)
            begin
                acc_reg <= acc_reg + ACC_W'(mul_reg);
            end
            if (cmd.perim_add)
            begin
                perim_reg <= (psum > perim_max) ? {PERIM_W{1'b1}} : psum[PERIM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            vx_reg   <= vertex_x;
            vy_reg   <= vertex_y;
            last_reg <= last_vertex;
        end
        if (cmd.load_edge)
        begin
            // Edge from the previous vertex a to vertex b.
            dx_reg <= EW'(prev_x_reg) - EW'(bx);
            dy_reg <= EW'(prev_y_reg) - EW'(by);
            sx_reg <= EW'(prev_x_reg) + EW'(bx);
        end
        if (cmd.mul_en)
        begin
            mul_reg <= prod;
        end
        if (cmd.rad_load)
        begin
            rad_reg <= PROD_W'(mul_reg);
        end
        else if (cmd.rad_add)
        begin
            rad_reg <= rad_reg + PROD_W'(mul_reg);
        end
        if (cmd.cen_x_load)
        begin
            cen_x_reg <= quotient[CENTER_W-1:0];
        end
        if (cmd.cen_y_load)
        begin
            cen_y_reg <= quotient[CENTER_W-1:0];
        end
        if (cmd.emit)
        begin
            area_reg      <= area_next;
            perim_out_reg <= perim_reg;
            cx_out_reg    <= cen_x_reg;
            cy_out_reg    <= cen_y_reg;
            cnt_out_reg   <= cnt_next;
            ovf_out_reg   <= ovf_reg;
        end
    end

    assign stat.cnt_zero  = (count_reg == '0);
    assign stat.cnt_full  = (count_reg >= CNT_W'(MAX_VERTICES));
    assign stat.last      = last_reg;
    assign stat.sqrt_done = sqrt_done;
    assign stat.div_done  = div_done;

    assign area_mag       = area_reg;
    assign perimeter_len  = perim_out_reg;
    assign center_x       = cx_out_reg;
    assign center_y       = cy_out_reg;
    assign vertex_count   = cnt_out_reg;
    assign count_overflow = ovf_out_reg;

endmodule

/* hw/rtl/ppc_ctrl.sv */
// Controller: sequences each vertex word through the datapath and owns both handshakes.
// Depends on ppc_pkg.
`timescale 1ns / 1ps
module ppc_ctrl
    import ppc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_DIFF,
        S_MUL_X,
        S_MUL_Y,
        S_MUL_C,
        S_SUM,
        S_SQRT,
        S_DIVX_GO,
        S_DIVX_WAIT,
        S_DIVY_GO,
        S_DIVY_WAIT,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   closing_reg, closing_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd            = '0;
        cmd.mul_sel    = MUL_DX;
        state_next     = state_reg;
        closing_next   = closing_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.cnt_zero || stat.cnt_full)
                begin
                    cmd.init    = stat.cnt_zero;
                    cmd.set_ovf = !stat.cnt_zero;
                    if (stat.last)
                    begin
                        closing_next = 1'b1;
                        state_next   = S_DIFF;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    closing_next = 1'b0;
                    state_next   = S_DIFF;
                end
            end
            S_DIFF:
            begin
                cmd.load_edge = 1'b1;
                cmd.close_sel = closing_reg;
                cmd.advance   = !closing_reg;
                state_next    = S_MUL_X;
            end
            S_MUL_X:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DX;
                state_next  = S_MUL_Y;
            end
            S_MUL_Y:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_DY;
                cmd.rad_load = 1'b1;
                state_next   = S_MUL_C;
            end
            S_MUL_C:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_CROSS;
                cmd.rad_add = 1'b1;
                state_next  = S_SUM;
            end
            S_SUM:
            begin
                cmd.acc_add    = 1'b1;
                cmd.sqrt_start = 1'b1;
                state_next     = S_SQRT;
            end
            S_SQRT:
            begin
                if (stat.sqrt_done)
                begin
                    cmd.perim_add = 1'b1;
                    if (closing_reg)
                    begin
                        state_next = S_DIVX_GO;
                    end
                    else if (stat.last)
                    begin
                        closing_next = 1'b1;
                        state_next   = S_DIFF;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_DIVX_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = 1'b0;
                state_next    = S_DIVX_WAIT;
            end
            S_DIVX_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.cen_x_load = 1'b1;
                    state_next     = S_DIVY_GO;
                end
            end
            S_DIVY_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = 1'b1;
                state_next    = S_DIVY_WAIT;
            end
            S_DIVY_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.cen_y_load = 1'b1;
                    state_next     = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // Load the result only when the output register is empty or its word is taken now.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit     = 1'b1;
                    closing_next = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            closing_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            closing_reg   <= closing_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* hw/rtl/polygon_area_perimeter_centroid.sv */
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready   vertex_x, vertex_y, last_vertex
// out       output     out_valid / out_ready area_mag, perimeter_len, center_x,
//                                            center_y, vertex_count, count_overflow
//
// A vertex word is captured, its edge is loaded, three products are formed (the
// squares of dx and dy and the cross term), and then the bit-serial square root
// of the edge length runs. The last vertex adds the closing edge and two serial
// divisions for the centroid. One word is in flight at a time.
// rst_n clears all polygon state at once. A result waits in the output register
// while the next polygon is taken in; only the next result load waits on out_ready.
`timescale 1ns / 1ps
module polygon_area_perimeter_centroid
    import ppc_pkg::*;
#(
    parameter int MAX_VERTICES = 256,
    parameter int COORD_BITS   = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] vertex_x,
    input  logic signed [COORD_BITS-1:0] vertex_y,
    input  logic                         last_vertex,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [AREA_W-1:0]            area_mag,
    output logic [PERIM_W-1:0]           perimeter_len,
    output logic signed [CENTER_W-1:0]   center_x,
    output logic signed [CENTER_W-1:0]   center_y,
    output logic [COUNT_OUT_W-1:0]       vertex_count,
    output logic                         count_overflow
);
    dp_cmd_t  cmd;
    dp_stat_t stat;

    ppc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    ppc_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .vertex_x       (vertex_x),
        .vertex_y       (vertex_y),
        .last_vertex    (last_vertex),
        .cmd            (cmd),
        .stat           (stat),
        .area_mag       (area_mag),
        .perimeter_len  (perimeter_len),
        .center_x       (center_x),
        .center_y       (center_y),
        .vertex_count   (vertex_count),
        .count_overflow (count_overflow)
    );

endmodule

/* hw/rtl/ppc_chk.sv */
// Port-level checker for the polygon block, attached to the top level by bind.
// Depends on ppc_pkg.
`timescale 1ns / 1ps
module ppc_chk
    import ppc_pkg::*;
#(
    parameter int MAX_VERTICES = 256,
    parameter int COORD_BITS   = 16
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic signed [COORD_BITS-1:0] vertex_x,
    input logic signed [COORD_BITS-1:0] vertex_y,
    input logic                         last_vertex,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [AREA_W-1:0]            area_mag,
    input logic [PERIM_W-1:0]           perimeter_len,
    input logic signed [CENTER_W-1:0]   center_x,
    input logic signed [CENTER_W-1:0]   center_y,
    input logic [COUNT_OUT_W-1:0]       vertex_count,
    input logic                         count_overflow
);
    localparam int SAT_COUNT = (MAX_VERTICES > 511) ? 511 : MAX_VERTICES;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(area_mag)
            && $stable(perimeter_len) && $stable(center_x) && $stable(center_y)
            && $stable(vertex_count) && $stable(count_overflow))
        else $error("result word changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second vertex taken while one is in work");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> vertex_count != '0)
        else $error("result with zero vertices");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && count_overflow |-> vertex_count == COUNT_OUT_W'(SAT_COUNT))
        else $error("overflow flagged below the vertex limit");

endmodule

bind polygon_area_perimeter_centroid ppc_chk #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
) u_ppc_chk (.*);
